### design/touch_trimmed_mean_calibrate_assert.svh
// Assertion macros for the touch trimmed-mean calibration block
`ifndef TOUCH_TRIMMED_MEAN_CALIBRATE_ASSERT_SVH
`define TOUCH_TRIMMED_MEAN_CALIBRATE_ASSERT_SVH

`ifndef SYNTHESIS
`define TMC_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define TMC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TMC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TMC_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define TMC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define TMC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

### design/tmc_pkg.sv
// Shared types and constants for the touch trimmed-mean calibration block
package tmc_pkg;

   localparam int SAMPLE_W   = 12;
   localparam int RAW_W      = 12;
   localparam int SCREEN_W   = 15;
   localparam int GAIN_W     = 20;
   localparam int OFFSET_W   = 16;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam int SAMPLE_MAX           = 4095;
   localparam int SAMPLES_PER_AXIS_DEF = 5;

   localparam logic signed [GAIN_W-1:0]   X_GAIN_RST   = 20'sd2281;
   localparam logic signed [GAIN_W-1:0]   Y_GAIN_RST   = 20'sd2822;
   localparam logic signed [OFFSET_W-1:0] X_OFFSET_RST = -16'sd5;
   localparam logic signed [OFFSET_W-1:0] Y_OFFSET_RST = -16'sd7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_GAIN   = 2'd0,
      CSR_Y_GAIN   = 2'd1,
      CSR_X_OFFSET = 2'd2,
      CSR_Y_OFFSET = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0]   gain;
      logic signed [OFFSET_W-1:0] offset;
   } cal_type;

endpackage

### design/tmc_if.sv
// Handshake channels: sample input, result output, register writes
interface tmc_req_if import tmc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface tmc_rsp_if import tmc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [RAW_W-1:0]    raw_x;
   logic [RAW_W-1:0]    raw_y;
   logic [SCREEN_W-1:0] screen_x;
   logic [SCREEN_W-1:0] screen_y;
   modport source (output valid, output raw_x, output raw_y, output screen_x,
                   output screen_y, input ready);
   modport sink   (input valid, input raw_x, input raw_y, input screen_x,
                   input screen_y, output ready);
endinterface

interface tmc_csr_if import tmc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### design/touch_trimmed_mean_calibrate.sv
// Touch trimmed-mean filter: one sample accepted per cycle, no gaps needed.
// After its last Y sample is accepted, a group's result passes through the close
// stage, then the calibration stage, then the output register.
// Input stalls only while a finished group sits in the close stage with both
// the calibration stage and the output register full and rsp ready low.
// Synchronous reset clears the sample position, accumulators, stage valids and
// loads the default calibration registers.
`include "touch_trimmed_mean_calibrate_assert.svh"

module touch_trimmed_mean_calibrate import tmc_pkg::*; #(
   parameter int SAMPLES_PER_AXIS = SAMPLES_PER_AXIS_DEF
) (
   input logic        clock,
   input logic        reset,
   tmc_req_if.sink    req_ch,
   tmc_rsp_if.source  rsp_ch,
   tmc_csr_if.sink    csr_ch
);

   localparam int GROUP  = 2 * SAMPLES_PER_AXIS;
   localparam int IDX_W  = $clog2(GROUP);
   localparam int SUM_W  = $clog2(SAMPLES_PER_AXIS * SAMPLE_MAX + 1);
   // floor division by SAMPLES_PER_AXIS - 2 as an exact reciprocal multiply
   localparam int DIV_D  = SAMPLES_PER_AXIS - 2;
   localparam int DIV_L  = $clog2(DIV_D);
   localparam int DIV_K  = SUM_W + DIV_L;
   localparam int M_W    = DIV_K + 1;
   localparam int DIV_M  = ((1 << DIV_K) + DIV_D - 1) / DIV_D;
   localparam int PROD_W = SUM_W + M_W;

   localparam logic [IDX_W-1:0] LAST_X = IDX_W'(SAMPLES_PER_AXIS - 1);
   localparam logic [IDX_W-1:0] LAST_Y = IDX_W'(GROUP - 1);
   localparam logic [IDX_W-1:0] FIRST_Y = IDX_W'(SAMPLES_PER_AXIS);

   // calibration registers
   cal_type cal_x_ff, cal_y_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_x_ff <= '{gain: X_GAIN_RST, offset: X_OFFSET_RST};
         cal_y_ff <= '{gain: Y_GAIN_RST, offset: Y_OFFSET_RST};
      end else if (csr_ch.valid) begin
         unique case (csr_idx_type'(csr_ch.index))
            CSR_X_GAIN:   cal_x_ff.gain   <= csr_ch.data;
            CSR_Y_GAIN:   cal_y_ff.gain   <= csr_ch.data;
            CSR_X_OFFSET: cal_x_ff.offset <= csr_ch.data[OFFSET_W-1:0];
            CSR_Y_OFFSET: cal_y_ff.offset <= csr_ch.data[OFFSET_W-1:0];
         endcase
      end
   end

   // accumulate stage
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [SUM_W-1:0]    sum_ff, sum_in, sum_add;
   logic [SAMPLE_W-1:0] min_ff, min_in, min_add;
   logic [SAMPLE_W-1:0] max_ff, max_in, max_add;
   logic                take, closing;

   // close stage
   logic                s1_v_ff, s1_v_in, s1_y_ff, s1_free;
   logic [SUM_W-1:0]    s1_sum_ff;
   logic [SAMPLE_W-1:0] s1_min_ff, s1_max_ff;
   logic [SUM_W-1:0]    trim;
   logic [PROD_W-1:0]   quot_prod;
   logic [RAW_W-1:0]    mean;
   logic [RAW_W-1:0]    held_x_ff;

   // calibration stage and output register
   logic                s2_v_ff, s2_v_in, s2_free, s2_load;
   logic [RAW_W-1:0]    s2_raw_x_ff, s2_raw_y_ff;
   logic                out_v_ff, out_v_in, out_free, out_load;
   logic [RAW_W-1:0]    out_raw_x_ff, out_raw_y_ff;
   logic [SCREEN_W-1:0] out_scr_x_ff, out_scr_y_ff, scr_x, scr_y;

   assign out_free = !out_v_ff || rsp_ch.ready;
   assign s2_free  = !s2_v_ff || out_free;
   assign s1_free  = !s1_v_ff || !s1_y_ff || s2_free;

   assign req_ch.ready = s1_free;
   assign take    = req_ch.valid && req_ch.ready;
   assign closing = (idx_ff == LAST_X) || (idx_ff == LAST_Y);

   assign sum_add = sum_ff + SUM_W'(req_ch.sample);
   assign min_add = (req_ch.sample < min_ff) ? req_ch.sample : min_ff;
   assign max_add = (req_ch.sample > max_ff) ? req_ch.sample : max_ff;

   always_comb begin
      idx_in = idx_ff;
      sum_in = sum_ff;
      min_in = min_ff;
      max_in = max_ff;
      if (take) begin
         idx_in = (idx_ff == LAST_Y) ? '0 : idx_ff + 1'b1;
         if (closing) begin
            sum_in = '0;
            min_in = '1;
            max_in = '0;
         end else begin
            sum_in = sum_add;
            min_in = min_add;
            max_in = max_add;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         sum_ff <= '0;
         min_ff <= '1;
         max_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         sum_ff <= sum_in;
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   // close stage: an X close just updates the held mean, a Y close moves on
   always_comb begin
      s1_v_in = s1_v_ff;
      if (take && closing) begin
         s1_v_in = 1'b1;
      end else if (s1_v_ff && (!s1_y_ff || s2_free)) begin
         s1_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
      end
      if (take && closing) begin
         s1_y_ff   <= (idx_ff == LAST_Y);
         s1_sum_ff <= sum_add;
         s1_min_ff <= min_add;
         s1_max_ff <= max_add;
      end
   end

   assign trim      = s1_sum_ff - SUM_W'(s1_min_ff) - SUM_W'(s1_max_ff);
   assign quot_prod = PROD_W'(trim) * PROD_W'(DIV_M);
   assign mean      = quot_prod[DIV_K+RAW_W-1:DIV_K];

   always_ff @(posedge clock) begin
      if (reset) begin
         held_x_ff <= '0;
      end else if (s1_v_ff && !s1_y_ff) begin
         held_x_ff <= mean;
      end
   end

   assign s2_load = s1_v_ff && s1_y_ff && s2_free;

   always_comb begin
      s2_v_in = s2_v_ff;
      if (s2_load) begin
         s2_v_in = 1'b1;
      end else if (out_free) begin
         s2_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s2_v_in;
      end
      if (s2_load) begin
         s2_raw_x_ff <= held_x_ff;
         s2_raw_y_ff <= mean;
      end
   end

   tmc_calib u_calib_x (
      .cal    (cal_x_ff),
      .raw    (s2_raw_x_ff),
      .screen (scr_x)
   );

   tmc_calib u_calib_y (
      .cal    (cal_y_ff),
      .raw    (s2_raw_y_ff),
      .screen (scr_y)
   );

   assign out_load = s2_v_ff && out_free;

   always_comb begin
      out_v_in = out_v_ff;
      if (out_load) begin
         out_v_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
      if (out_load) begin
         out_raw_x_ff <= s2_raw_x_ff;
         out_raw_y_ff <= s2_raw_y_ff;
         out_scr_x_ff <= scr_x;
         out_scr_y_ff <= scr_y;
      end
   end

   assign rsp_ch.valid    = out_v_ff;
   assign rsp_ch.raw_x    = out_raw_x_ff;
   assign rsp_ch.raw_y    = out_raw_y_ff;
   assign rsp_ch.screen_x = out_scr_x_ff;
   assign rsp_ch.screen_y = out_scr_y_ff;

   `TMC_ASSERT_ALWAYS(a_idx_range, clock, reset, idx_ff <= LAST_Y, "sample position out of group")
   `TMC_ASSERT_IMP(a_min_le_max, clock, reset, (idx_ff != '0) && (idx_ff != FIRST_Y), min_ff <= max_ff, "running min above running max")
   `TMC_ASSERT_NEXT(a_y_close_moves, clock, reset, s1_v_ff && s1_y_ff && s2_free, s2_v_ff, "Y close lost before calibration")
   `TMC_ASSERT_NEXT(a_s2_to_out, clock, reset, s2_v_ff && out_free, rsp_ch.valid, "calibrated item not presented")

endmodule

### design/tmc_calib.sv
// Linear calibration of one axis: gain * raw + offset, truncated and clamped
module tmc_calib import tmc_pkg::*; (
   input  cal_type             cal,
   input  logic [RAW_W-1:0]    raw,
   output logic [SCREEN_W-1:0] screen
);

   localparam int PROD_W = GAIN_W + RAW_W + 1;
   localparam int OFFS_W = OFFSET_W + FRAC_W;
   localparam int ACC_W  = PROD_W + 1;

   logic signed [PROD_W-1:0] prod;
   logic signed [OFFS_W-1:0] offs_sh;
   logic signed [ACC_W-1:0]  acc;

   assign prod    = PROD_W'(cal.gain) * PROD_W'($signed({1'b0, raw}));
   assign offs_sh = {cal.offset, FRAC_W'(0)};
   assign acc     = ACC_W'(prod) + ACC_W'(offs_sh);

   // non-negative sum: shifting right is truncation toward zero
   always_comb begin
      if (acc[ACC_W-1]) begin
         screen = '0;
      end else if (|acc[ACC_W-2:FRAC_W+SCREEN_W]) begin
         screen = '1;
      end else begin
         screen = acc[FRAC_W+SCREEN_W-1:FRAC_W];
      end
   end

endmodule

### sim/testbench.sv
// Self-checking testbench for the touch trimmed-mean filter with calibration
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tmc_pkg::*;

   localparam int AXIS_LEN      = SAMPLES_PER_AXIS_DEF;
   localparam int GAIN_MAX      = 2 ** (GAIN_W - 1) - 1;
   localparam int GAIN_MIN      = -(2 ** (GAIN_W - 1));
   localparam int OFS_MAX       = 2 ** (OFFSET_W - 1) - 1;
   localparam int OFS_MIN       = -(2 ** (OFFSET_W - 1));
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int PHASE_ITEMS   = 150;
   localparam int PHASE_COUNT   = 9;

   typedef struct packed {
      logic [RAW_W-1:0]    raw_x;
      logic [RAW_W-1:0]    raw_y;
      logic [SCREEN_W-1:0] screen_x;
      logic [SCREEN_W-1:0] screen_y;
   } touch_point_type;

   class touch_scoreboard_type;
      logic signed [GAIN_W-1:0]   gain_x, gain_y;
      logic signed [OFFSET_W-1:0] ofs_x, ofs_y;
      logic [3:0]                 position;
      logic [14:0]                acc_sum;
      logic [RAW_W-1:0]           acc_min, acc_max, held_x;
      touch_point_type            pending_points[$];
      int                         errors, points_checked, samples_taken;

      function new();
         gain_x   = X_GAIN_RST;
         gain_y   = Y_GAIN_RST;
         ofs_x    = X_OFFSET_RST;
         ofs_y    = Y_OFFSET_RST;
         position = '0;
         acc_sum  = '0;
         acc_min  = '1;
         acc_max  = '0;
         held_x   = '0;
         errors   = 0;
         points_checked = 0;
         samples_taken  = 0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_X_GAIN:   gain_x = data[GAIN_W-1:0];
            CSR_Y_GAIN:   gain_y = data[GAIN_W-1:0];
            CSR_X_OFFSET: ofs_x  = data[OFFSET_W-1:0];
            CSR_Y_OFFSET: ofs_y  = data[OFFSET_W-1:0];
            default: ;
         endcase
      endfunction

      // sum always covers min + max, so the subtraction never wraps
      function logic [RAW_W-1:0] close_axis();
         logic [14:0] trimmed;
         logic [14:0] mean;
         trimmed = acc_sum - 15'(acc_min) - 15'(acc_max);
         mean    = trimmed / 15'(AXIS_LEN - 2);
         acc_sum = '0;
         acc_min = '1;
         acc_max = '0;
         return mean[RAW_W-1:0];
      endfunction

      function logic [SCREEN_W-1:0] calibrate_axis(logic signed [GAIN_W-1:0] gain,
                                                    logic signed [OFFSET_W-1:0] ofs,
                                                    logic [RAW_W-1:0] raw);
         longint prod;
         longint pix;
         prod = longint'(gain) * longint'(raw) + longint'(ofs) * 65536;
         if (prod < 0) return '0;
         pix = prod >>> FRAC_W;
         if (pix > 32767) return 15'h7FFF;
         return pix[SCREEN_W-1:0];
      endfunction

      function void take_sample(logic [SAMPLE_W-1:0] s);
         touch_point_type pt;
         logic [RAW_W-1:0] mean_y;
         samples_taken++;
         acc_sum = acc_sum + 15'(s);
         if (s < acc_min) acc_min = s;
         if (s > acc_max) acc_max = s;
         if (position == 4'(AXIS_LEN - 1)) begin
            held_x   = close_axis();
            position = position + 4'd1;
         end else if (position == 4'(2 * AXIS_LEN - 1)) begin
            mean_y      = close_axis();
            position    = '0;
            pt.raw_x    = held_x;
            pt.raw_y    = mean_y;
            pt.screen_x = calibrate_axis(gain_x, ofs_x, held_x);
            pt.screen_y = calibrate_axis(gain_y, ofs_y, mean_y);
            pending_points.push_back(pt);
         end else begin
            position = position + 4'd1;
         end
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH: %s", msg);
      endtask

      task check_point(touch_point_type got);
         touch_point_type want;
         if (pending_points.size() == 0) begin
            report($sformatf("point with nothing pending: raw %0d,%0d screen %0d,%0d",
                             got.raw_x, got.raw_y, got.screen_x, got.screen_y));
            return;
         end
         want = pending_points.pop_front();
         points_checked++;
         if (got.raw_x !== want.raw_x)
            report($sformatf("raw_x got %0d want %0d", got.raw_x, want.raw_x));
         if (got.raw_y !== want.raw_y)
            report($sformatf("raw_y got %0d want %0d", got.raw_y, want.raw_y));
         if (got.screen_x !== want.screen_x)
            report($sformatf("screen_x got %0d want %0d", got.screen_x, want.screen_x));
         if (got.screen_y !== want.screen_y)
            report($sformatf("screen_y got %0d want %0d", got.screen_y, want.screen_y));
      endtask
   endclass

   logic clock;
   logic reset;

   tmc_req_if req_ch();
   tmc_rsp_if rsp_ch();
   tmc_csr_if csr_ch();

   touch_trimmed_mean_calibrate u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   touch_scoreboard_type points;
   touch_point_type      seen;
   int                   cycle_count = 0;
   int                   cal_settings = 1;
   bit                   send_gaps_on = 1'b1;
   bit                   recv_stalls_on = 1'b1;
   int                   stim_slot = 0;
   int                   axis_mode = 0;
   int                   axis_base = 0;
   int                   hold_left = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // accepted items are noted at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready)
            points.write_reg(csr_idx_type'(csr_ch.index), csr_ch.data);
         if (req_ch.valid && req_ch.ready)
            points.take_sample(req_ch.sample);
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.raw_x    = rsp_ch.raw_x;
            seen.raw_y    = rsp_ch.raw_y;
            seen.screen_x = rsp_ch.screen_x;
            seen.screen_y = rsp_ch.screen_y;
            points.check_point(seen);
         end
      end
   end

   // mostly short, now and then long
   function automatic int draw_gap();
      if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   initial begin
      rsp_ch.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready = 1'b1;
            if (recv_stalls_on && $urandom_range(0, 99) < 30) hold_left = draw_gap();
         end
      end
   end

   // tasks start and end just after a falling edge
   task automatic push_sample(input logic [SAMPLE_W-1:0] s);
      int gap;
      gap = 0;
      if (send_gaps_on && $urandom_range(0, 99) < 35) gap = draw_gap();
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid  = 1'b1;
      req_ch.sample = s;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (points.pending_points.size() != 0) @(negedge clock);
   endtask

   // offsets carry random bits above their width, which must be ignored
   task automatic program_cal(input int xg, input int yg, input int xo, input int yo);
      req_ch.valid = 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_csr(CSR_X_GAIN, CSR_DATA_W'(xg));
      write_csr(CSR_Y_GAIN, CSR_DATA_W'(yg));
      write_csr(CSR_X_OFFSET, {4'($urandom_range(0, 15)), 16'(xo)});
      write_csr(CSR_Y_OFFSET, {4'($urandom_range(0, 15)), 16'(yo)});
      csr_ch.valid = 1'b0;
      cal_settings++;
   endtask

   function automatic int draw_gain();
      if ($urandom_range(0, 1)) return int'($urandom_range(0, 32768)) - 16384;
      return int'($urandom_range(0, 2 ** GAIN_W - 1)) + GAIN_MIN;
   endfunction

   function automatic int draw_offset();
      if ($urandom_range(0, 1)) return int'($urandom_range(0, 400)) - 200;
      return int'($urandom_range(0, 2 ** OFFSET_W - 1)) + OFS_MIN;
   endfunction

   // each axis gets a style: pen jitter around one value, noise or extremes
   function automatic logic [SAMPLE_W-1:0] next_sample();
      int v;
      if (stim_slot % AXIS_LEN == 0) begin
         axis_mode = $urandom_range(0, 9);
         axis_base = $urandom_range(0, SAMPLE_MAX);
      end
      stim_slot = (stim_slot + 1) % (2 * AXIS_LEN);
      case (axis_mode) inside
         [0:5]:   v = axis_base + int'($urandom_range(0, 40)) - 20;
         [6:7]:   v = $urandom_range(0, SAMPLE_MAX);
         8:       v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
         default: v = $urandom_range(0, 1) ? int'($urandom_range(SAMPLE_MAX - 15,
                                                               SAMPLE_MAX))
                                            : int'($urandom_range(0, 15));
      endcase
      if (v < 0) v = 0;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      return SAMPLE_W'(v);
   endfunction

   task automatic run_phase(input int count, input bit pause_midway);
      int k;
      for (k = 0; k < count; k++) begin
         if (pause_midway && k == count / 2) begin
            req_ch.valid = 1'b0;
            wait_drained();
         end
         push_sample(next_sample());
      end
   endtask

   initial begin
      logic [SAMPLE_W-1:0] directed[$];
      int p;
      points        = new();
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.sample = '0;
      csr_ch.valid  = 1'b0;
      csr_ch.index  = CSR_X_GAIN;
      csr_ch.data   = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // full-scale swings on X, full-scale Y (widest sum), then zeros and edges
      directed = '{12'd0, 12'hFFF, 12'd0, 12'hFFF, 12'd0,
                   12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                   12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
                   12'h800, 12'h001, 12'hFFE, 12'h7FF, 12'hAAA};
      foreach (directed[i]) push_sample(directed[i]);

      for (p = 0; p < PHASE_COUNT; p++) begin
         send_gaps_on   = 1'b1;
         recv_stalls_on = 1'b1;
         case (p) inside
            1:       program_cal(GAIN_MAX, GAIN_MIN, OFS_MAX, OFS_MIN);
            2:       program_cal(GAIN_MIN, GAIN_MAX, OFS_MIN, OFS_MAX);
            3:       program_cal(0, 0, draw_offset(), draw_offset());
            4:       program_cal(65536, 131072, 0, 0);
            [5:7]:   program_cal(draw_gain(), draw_gain(), draw_offset(), draw_offset());
            8:       program_cal(X_GAIN_RST, Y_GAIN_RST, X_OFFSET_RST, Y_OFFSET_RST);
            default: ;
         endcase
         if (p == 5) begin
            send_gaps_on   = 1'b0;
            recv_stalls_on = 1'b0;
         end
         run_phase(PHASE_ITEMS + (p % 3), p == 6);
      end

      req_ch.valid = 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (points.pending_points.size() != 0)
         points.report($sformatf("%0d points never came", points.pending_points.size()));

      $display("Fed %0d samples and checked %0d touch points over %0d calibration settings",
               points.samples_taken, points.points_checked, cal_settings);
      $display("Settings included gain and offset extremes, zero gain and the reset values");
      if (points.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
